/* rtl/xrm_pkg.sv */
package xrm_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned RANGE_W = 31;
    localparam int unsigned STEP_W  = 5;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'hF0C5_F0C5;
    localparam logic [SEED_W-1:0] SEED_XOR   = 32'h1D87_2B41;
    localparam int unsigned       SHIFT_R    = 5;
    localparam int unsigned       SHIFT_L    = 27;

    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } t_back_state;

    // One command for the back end. The dividend is the seed as it stood
    // before the draw advanced it.
    typedef struct packed {
        logic               is_div;
        logic [SEED_W-1:0]  dividend;
        logic [RANGE_W-1:0] divisor;
    } t_cmd;

    function automatic logic [SEED_W-1:0] advance_seed(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] n;
        logic [SEED_W-1:0] t;
        n = s ^ SEED_XOR;
        t = n ^ (n >> SHIFT_R);
        return t ^ n ^ (t << SHIFT_L);
    endfunction

endpackage

/* rtl/xorshift_random_modulo.sv */
// Xorshift generator with a 32-bit seed that returns the seed modulo a range.
// A draw beat returns the current seed modulo i_range_limit and advances the
// seed; a zero range returns 0 and keeps the seed; a reseed beat loads
// i_seed_value and returns 0. The front end updates the seed as soon as a
// beat is accepted and hands the remainder job to a short queue, so up to
// QUEUE_DEPTH beats are taken ahead of the back end. The back end works on
// one job at a time with a radix-2 restoring divider: a draw with a nonzero
// range occupies it for a load step, 32 quotient steps and a step that
// writes the output register; a reseed or zero-range draw only for the load
// and the write. Sustained draw throughput is therefore set by the divider
// loop. The output register lets the next job run while a result waits on
// o_valid.
module xorshift_random_modulo #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [xrm_pkg::RANGE_W-1:0]  i_range_limit,
    input  logic [xrm_pkg::SEED_W-1:0]   i_seed_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [xrm_pkg::RANGE_W-1:0]  o_random_value
);
    import xrm_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    xrm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_op          (i_op),
        .i_range_limit (i_range_limit),
        .i_seed_value  (i_seed_value),
        .i_full        (full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    xrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    xrm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

endmodule

/* rtl/xrm_front.sv */
module xrm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_op,
    input  logic [xrm_pkg::RANGE_W-1:0]  i_range_limit,
    input  logic [xrm_pkg::SEED_W-1:0]   i_seed_value,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output xrm_pkg::t_cmd                o_cmd
);
    import xrm_pkg::*;

    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] n_seed;
    logic              draw;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Only a draw with a nonzero range needs the divider.
    assign draw = (t_op'(i_op) == OP_DRAW) && (i_range_limit != '0);

    always_comb begin
        n_seed = r_seed;
        if (o_push) begin
            if (t_op'(i_op) == OP_RESEED) begin
                n_seed = i_seed_value;
            end else if (draw) begin
                n_seed = advance_seed(r_seed);
            end
        end
    end

    always_comb begin
        o_cmd.is_div   = draw;
        o_cmd.dividend = r_seed;
        o_cmd.divisor  = i_range_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else begin
            r_seed <= n_seed;
        end
    end

endmodule

/* rtl/xrm_queue.sv */
module xrm_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xrm_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output xrm_pkg::t_cmd  o_cmd
);
    import xrm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/xrm_back.sv */
module xrm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  xrm_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [xrm_pkg::RANGE_W-1:0]  o_random_value
);
    import xrm_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [STEP_W-1:0]  r_cnt;
    logic [STEP_W-1:0]  n_cnt;
    logic [RANGE_W-1:0] r_rem;
    logic [RANGE_W-1:0] n_rem;
    logic [SEED_W-1:0]  r_dvd;
    logic [SEED_W-1:0]  n_dvd;
    logic [RANGE_W-1:0] r_div;
    logic [RANGE_W-1:0] n_div;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [RANGE_W-1:0] r_out_data;
    logic [RANGE_W-1:0] n_out_data;
    logic [SEED_W-1:0]  shifted;
    logic [SEED_W-1:0]  diff;
    logic               out_free;

    // Restoring division, one quotient bit per cycle. The partial remainder
    // stays below the divisor, so it fits in the divisor's width.
    assign shifted  = {r_rem, r_dvd[SEED_W-1]};
    assign diff     = shifted - {1'b0, r_div};
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_div       = r_div;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_rem = '0;
                    n_dvd = i_cmd.dividend;
                    n_div = i_cmd.divisor;
                    n_cnt = STEP_W'(SEED_W - 1);
                    n_state = i_cmd.is_div ? BS_DIV : BS_DONE;
                end
            end
            BS_DIV: begin
                n_dvd = r_dvd << 1;
                if (!diff[SEED_W-1]) begin
                    n_rem = diff[RANGE_W-1:0];
                end else begin
                    n_rem = shifted[RANGE_W-1:0];
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rem;
                    n_state     = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_div      <= n_div;
        r_out_data <= n_out_data;
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_data;

endmodule
